[rtl/deadline_timer_queue_macros.svh]
// assertion macros for the checker file of the deadline timer queue
// expects signals named clk and arst_n in the scope where a macro is used
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dtq_pkg.sv]
// shared types and codes of the deadline timer queue
// no dependencies; used by dtq_cell, the top level and the checker
package dtq_pkg;

	// fixed field widths of the stream payload
	localparam int FIELD_TIME_W = 48;
	localparam int PERIOD_W     = 32;
	localparam int RESULT_ID_W  = 4;
	localparam int STATUS_W     = 3;
	localparam int OPCODE_W     = 2;
	localparam int MIN_DELAY_W  = 20;
	localparam int SEL_BITS     = 8;

	localparam logic [MIN_DELAY_W-1:0] MIN_DELAY_RESET = 20'd100;

	// request opcodes
	localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSED    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

	// what the cells do this cycle (mark acts on every cell, the others on the addressed one)
	typedef enum logic [2:0] {
		CELL_NOP,
		CELL_WRITE,
		CELL_CANCEL,
		CELL_MARK,
		CELL_FIRE
	} cell_op_t;

	// which cells take part in the running search and by what key
	typedef enum logic [1:0] {
		SCAN_FREE,
		SCAN_MATCH,
		SCAN_DUE,
		SCAN_LIVE
	} scan_mode_t;

	typedef struct packed {
		cell_op_t           op;
		scan_mode_t         mode;
		logic [SEL_BITS-1:0] sel;
	} cell_cmd_t;

endpackage

[rtl/dtq_cell.sv]
// one timer slot of the chain: deadline, period, live and due flags
// plus one registered stage of the running minimum search; uses dtq_pkg
module dtq_cell #(
	parameter int TIME_BITS = 48,
	parameter int ID_W      = 4,
	parameter int CELL_IDX  = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtq_pkg::cell_cmd_t            cmd,
	input  logic [TIME_BITS-1:0]          wr_deadline,
	input  logic [dtq_pkg::PERIOD_W-1:0]  wr_period,
	input  logic [TIME_BITS-1:0]          now,
	input  logic                          cand_vld_in,
	input  logic [TIME_BITS-1:0]          cand_key_in,
	input  logic [ID_W-1:0]               cand_id_in,
	output logic                          cand_vld_out,
	output logic [TIME_BITS-1:0]          cand_key_out,
	output logic [ID_W-1:0]               cand_id_out
);

	logic                         live_q;
	logic                         due_q;
	logic [TIME_BITS-1:0]         deadline_q;
	logic [dtq_pkg::PERIOD_W-1:0] period_q;
	logic                         cand_vld_q;
	logic [TIME_BITS-1:0]         cand_key_q;
	logic [ID_W-1:0]              cand_id_q;

	logic                 sel_hit;
	logic [TIME_BITS:0]   reload_sum;
	logic [TIME_BITS-1:0] reload_dl;
	logic                 elig;
	logic [TIME_BITS-1:0] own_key;
	logic                 take_own;

	assign sel_hit    = (cmd.sel == dtq_pkg::SEL_BITS'(CELL_IDX));
	assign reload_sum = {1'b0, now} + (TIME_BITS+1)'(period_q);
	// saturate at the largest time
	assign reload_dl  = reload_sum[TIME_BITS] ? '1 : reload_sum[TIME_BITS-1:0];

	always_comb begin
		elig    = 1'b0;
		own_key = '0;
		unique case (cmd.mode)
			dtq_pkg::SCAN_FREE: begin
				elig = !live_q;
			end
			dtq_pkg::SCAN_MATCH: begin
				elig = live_q && sel_hit;
			end
			dtq_pkg::SCAN_DUE: begin
				elig    = due_q;
				own_key = deadline_q;
			end
			dtq_pkg::SCAN_LIVE: begin
				elig    = live_q;
				own_key = deadline_q;
			end
			default: begin
				elig = 1'b0;
			end
		endcase
	end

	// strict compare: on a tie the lower slot, already in the chain, stays
	assign take_own = elig && (!cand_vld_in || (own_key < cand_key_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= 1'b0;
			due_q      <= 1'b0;
			cand_vld_q <= 1'b0;
		end else begin
			cand_vld_q <= take_own || cand_vld_in;
			unique case (cmd.op)
				dtq_pkg::CELL_WRITE: begin
					if (sel_hit) live_q <= 1'b1;
				end
				dtq_pkg::CELL_CANCEL: begin
					if (sel_hit) live_q <= 1'b0;
				end
				dtq_pkg::CELL_MARK: begin
					due_q <= live_q && (deadline_q <= now);
				end
				dtq_pkg::CELL_FIRE: begin
					if (sel_hit) begin
						due_q <= 1'b0;
						if (period_q == '0) live_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cand_key_q <= take_own ? own_key : cand_key_in;
		cand_id_q  <= take_own ? ID_W'(CELL_IDX) : cand_id_in;
		if ((cmd.op == dtq_pkg::CELL_WRITE) && sel_hit) begin
			deadline_q <= wr_deadline;
			period_q   <= wr_period;
		end else if ((cmd.op == dtq_pkg::CELL_FIRE) && sel_hit && (period_q != '0)) begin
			deadline_q <= reload_dl;
		end
	end

	assign cand_vld_out = cand_vld_q;
	assign cand_key_out = cand_key_q;
	assign cand_id_out  = cand_id_q;

endmodule

[rtl/deadline_timer_queue.sv]
// deadline timer queue: TIMER_SLOTS timer cells in a chain plus a sequencer
// each search lets a candidate walk the chain, cell by cell
// add: free search, then write, live search, rearm; cancel: match search, clear;
// tick: mark, due search and fire per due timer, live search, rearm
// one request at a time; the next is taken while the last result still waits
// arst_n low clears all timers, the armed deadline, and sets min_arm_delay to 100
module deadline_timer_queue #(
	parameter int TIMER_SLOTS = 16,
	parameter int TIME_BITS   = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration: min_arm_delay
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [19:0]  cfg_data,
	// request stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// timer_id [3:0], deadline [51:4], period [83:52], now [131:84], zero pad
	input  logic [135:0] s_axis_tdata,
	// opcode [1:0]
	input  logic [1:0]   s_axis_tuser,
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_id [3:0], rearm_delay [51:4], next_deadline [99:52], zero pad
	output logic [103:0] m_axis_tdata,
	// status [2:0], rearm [3]
	output logic [3:0]   m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam int ID_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int TW    = dtq_pkg::FIELD_TIME_W;
	localparam int RW    = dtq_pkg::RESULT_ID_W;
	localparam int SW    = dtq_pkg::SEL_BITS;
	localparam int PW    = dtq_pkg::PERIOD_W;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_SCAN,
		S_ADD_WR,
		S_CAN_SCAN,
		S_CAN_CLR,
		S_TICK_MARK,
		S_DUE_SCAN,
		S_FIRE,
		S_LIVE_SCAN,
		S_REARM,
		S_EMIT
	} state_t;

	state_t                      state_q;
	state_t                      ret_q;
	logic [CNT_W-1:0]            cnt_q;
	dtq_pkg::scan_mode_t         mode_q;
	logic [SW-1:0]               sel_q;
	logic [RW-1:0]               in_timer_id_q;
	logic [TIME_BITS-1:0]        in_deadline_q;
	logic [PW-1:0]               in_period_q;
	logic [TIME_BITS-1:0]        in_now_q;
	logic                        have_pend_q;
	logic [ID_W-1:0]             pend_id_q;
	logic [dtq_pkg::STATUS_W-1:0] res_status_q;
	logic [RW-1:0]               res_id_q;
	logic                        res_rearm_q;
	logic [TW-1:0]               res_delay_q;
	logic [TW-1:0]               res_next_q;
	logic                        res_last_q;
	logic [TIME_BITS-1:0]        armed_dl_q;
	logic                        armed_vld_q;
	logic [dtq_pkg::MIN_DELAY_W-1:0] min_arm_delay_q;
	logic                        out_vld_q;
	logic [103:0]                out_data_q;
	logic [3:0]                  out_user_q;
	logic                        out_last_q;

	// candidate chain, slot 0 is fed an empty candidate
	logic [TIMER_SLOTS:0]        chain_vld;
	logic [TIME_BITS-1:0]        chain_key [TIMER_SLOTS+1];
	logic [ID_W-1:0]             chain_id  [TIMER_SLOTS+1];

	dtq_pkg::cell_cmd_t          cmd;
	dtq_pkg::cell_op_t           cell_op;

	logic                        scan_done;
	logic                        best_vld;
	logic [TIME_BITS-1:0]        best_dl;
	logic [ID_W-1:0]             best_id;
	logic [TIME_BITS-1:0]        diff;
	logic [TIME_BITS-1:0]        floor_dl;
	logic [TIME_BITS-1:0]        delay;
	logic                        do_rearm;
	logic                        out_free;

	// config reg always writable; the user must write only while idle (not enforced)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_arm_delay_q <= dtq_pkg::MIN_DELAY_RESET;
		end else if (cfg_valid) begin
			min_arm_delay_q <= cfg_data;
		end
	end

	// the cell command: one-cycle updates come from the state, the search from mode_q
	always_comb begin
		unique case (state_q)
			S_ADD_WR:    cell_op = dtq_pkg::CELL_WRITE;
			S_CAN_CLR:   cell_op = dtq_pkg::CELL_CANCEL;
			S_TICK_MARK: cell_op = dtq_pkg::CELL_MARK;
			S_FIRE:      cell_op = dtq_pkg::CELL_FIRE;
			default:     cell_op = dtq_pkg::CELL_NOP;
		endcase
	end

	assign cmd = '{op: cell_op, mode: mode_q, sel: sel_q};

	assign chain_vld[0] = 1'b0;
	assign chain_key[0] = '0;
	assign chain_id[0]  = '0;

	for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
		dtq_cell #(
			.TIME_BITS (TIME_BITS),
			.ID_W      (ID_W),
			.CELL_IDX  (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.wr_deadline  (in_deadline_q),
			.wr_period    (in_period_q),
			.now          (in_now_q),
			.cand_vld_in  (chain_vld[g]),
			.cand_key_in  (chain_key[g]),
			.cand_id_in   (chain_id[g]),
			.cand_vld_out (chain_vld[g+1]),
			.cand_key_out (chain_key[g+1]),
			.cand_id_out  (chain_id[g+1])
		);
	end

	// the chain end holds the winner once cnt_q reaches TIMER_SLOTS in a search state
	assign scan_done = (cnt_q == CNT_W'(TIMER_SLOTS));
	assign best_vld  = chain_vld[TIMER_SLOTS];
	assign best_dl   = chain_key[TIMER_SLOTS];
	assign best_id   = chain_id[TIMER_SLOTS];

	// rearm delay: time to the earliest deadline, floored at min_arm_delay
	assign diff     = (best_dl > in_now_q) ? (best_dl - in_now_q) : '0;
	assign floor_dl = TIME_BITS'(min_arm_delay_q);
	assign delay    = (diff < floor_dl) ? floor_dl : diff;
	assign do_rearm = best_vld && (!armed_vld_q || (best_dl < armed_dl_q));

	// output register is free when empty or being taken this cycle
	assign out_free = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			cnt_q         <= '0;
			mode_q        <= dtq_pkg::SCAN_FREE;
			sel_q         <= '0;
			in_timer_id_q <= '0;
			in_deadline_q <= '0;
			in_period_q   <= '0;
			in_now_q      <= '0;
			have_pend_q   <= 1'b0;
			pend_id_q     <= '0;
			res_status_q  <= '0;
			res_id_q      <= '0;
			res_rearm_q   <= 1'b0;
			res_delay_q   <= '0;
			res_next_q    <= '0;
			res_last_q    <= 1'b0;
			armed_dl_q    <= '0;
			armed_vld_q   <= 1'b0;
			out_vld_q     <= 1'b0;
			out_data_q    <= '0;
			out_user_q    <= '0;
			out_last_q    <= 1'b0;
		end else begin
			// a new result loads the output register, otherwise a taken one leaves it
			if ((state_q == S_EMIT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						in_timer_id_q <= s_axis_tdata[3:0];
						in_deadline_q <= TIME_BITS'(s_axis_tdata[51:4]);
						in_period_q   <= s_axis_tdata[83:52];
						in_now_q      <= TIME_BITS'(s_axis_tdata[131:84]);
						sel_q         <= SW'(s_axis_tdata[3:0]);
						cnt_q         <= '0;
						res_rearm_q   <= 1'b0;
						res_delay_q   <= '0;
						res_next_q    <= '0;
						res_last_q    <= 1'b1;
						unique case (s_axis_tuser)
							dtq_pkg::OP_ADD: begin
								mode_q  <= dtq_pkg::SCAN_FREE;
								state_q <= S_ADD_SCAN;
							end
							dtq_pkg::OP_CANCEL: begin
								mode_q  <= dtq_pkg::SCAN_MATCH;
								state_q <= S_CAN_SCAN;
							end
							dtq_pkg::OP_TICK: begin
								state_q <= S_TICK_MARK;
							end
							default: begin
								// unknown opcode is dropped without a result
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!best_vld) begin
						res_status_q <= dtq_pkg::ST_FULL;
						res_id_q     <= '0;
						ret_q        <= S_IDLE;
						state_q      <= S_EMIT;
					end else begin
						sel_q   <= SW'(best_id);
						state_q <= S_ADD_WR;
					end
				end
				S_ADD_WR: begin
					res_status_q <= dtq_pkg::ST_ADDED;
					res_id_q     <= RW'(sel_q[ID_W-1:0]);
					mode_q       <= dtq_pkg::SCAN_LIVE;
					cnt_q        <= '0;
					state_q      <= S_LIVE_SCAN;
				end
				S_CAN_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						res_id_q <= in_timer_id_q;
						ret_q    <= S_IDLE;
						if (best_vld) begin
							res_status_q <= dtq_pkg::ST_CANCELLED;
							state_q      <= S_CAN_CLR;
						end else begin
							res_status_q <= dtq_pkg::ST_MISSED;
							state_q      <= S_EMIT;
						end
					end
				end
				S_CAN_CLR: begin
					state_q <= S_EMIT;
				end
				S_TICK_MARK: begin
					armed_vld_q <= 1'b0;
					have_pend_q <= 1'b0;
					mode_q      <= dtq_pkg::SCAN_DUE;
					cnt_q       <= '0;
					state_q     <= S_DUE_SCAN;
				end
				S_DUE_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (best_vld) begin
						sel_q   <= SW'(best_id);
						state_q <= S_FIRE;
					end else begin
						// no more due timers: the held one, if any, becomes the last result, else status none
						res_status_q <= have_pend_q ? dtq_pkg::ST_FIRED : dtq_pkg::ST_NONE;
						res_id_q     <= have_pend_q ? RW'(pend_id_q) : '0;
						res_last_q   <= 1'b1;
						mode_q       <= dtq_pkg::SCAN_LIVE;
						cnt_q        <= '0;
						state_q      <= S_LIVE_SCAN;
					end
				end
				S_FIRE: begin
					// hold back the newest fired id until we know whether it is the last
					pend_id_q   <= sel_q[ID_W-1:0];
					have_pend_q <= 1'b1;
					cnt_q       <= '0;
					if (have_pend_q) begin
						res_status_q <= dtq_pkg::ST_FIRED;
						res_id_q     <= RW'(pend_id_q);
						res_last_q   <= 1'b0;
						ret_q        <= S_DUE_SCAN;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_DUE_SCAN;
					end
				end
				S_LIVE_SCAN: begin
					if (!scan_done) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_REARM;
					end
				end
				S_REARM: begin
					res_last_q <= 1'b1;
					ret_q      <= S_IDLE;
					state_q    <= S_EMIT;
					if (do_rearm) begin
						armed_dl_q  <= best_dl;
						armed_vld_q <= 1'b1;
						res_rearm_q <= 1'b1;
						res_delay_q <= TW'(delay);
						res_next_q  <= TW'(best_dl);
					end else begin
						res_rearm_q <= 1'b0;
						res_delay_q <= '0;
						res_next_q  <= '0;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_data_q <= {4'b0, res_next_q, res_delay_q, res_id_q};
						out_user_q <= {res_rearm_q, res_status_q};
						out_last_q <= res_last_q;
						cnt_q      <= '0;
						state_q    <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

[rtl/dtq_checker.sv]
// port-level checks on the result stream of the deadline timer queue
// uses dtq_pkg and deadline_timer_queue_macros.svh; bound to the top level below
`include "deadline_timer_queue_macros.svh"

module dtq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic [3:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// a stalled result keeps its contents
	`DTQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

	// a rearm request only rides on the final result of a request
	`DTQ_ASSERT_NOW(a_rearm_last, m_axis_tvalid && m_axis_tuser[3], m_axis_tlast, "rearm on a non-final result")

	// without a rearm the delay and deadline fields are zero
	`DTQ_ASSERT_NOW(a_rearm_zero, m_axis_tvalid && !m_axis_tuser[3], m_axis_tdata[99:4] == '0, "rearm fields set without rearm")

	// add and cancel requests give a single result
	`DTQ_ASSERT_NOW(a_single, m_axis_tvalid && (m_axis_tuser[2:0] == dtq_pkg::ST_ADDED || m_axis_tuser[2:0] == dtq_pkg::ST_FULL || m_axis_tuser[2:0] == dtq_pkg::ST_CANCELLED || m_axis_tuser[2:0] == dtq_pkg::ST_MISSED), m_axis_tlast, "add or cancel result not final")

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
